### design/rft_pkg.sv
// shared types and constants for the five-slot ranking table
package rft_pkg;

   localparam int NUM_SLOTS  = 5;
   localparam int KEY_BITS   = 32;
   localparam int TOTAL_BITS = 33;
   localparam int POS_BITS   = $clog2(NUM_SLOTS + 1);

   localparam logic [TOTAL_BITS-1:0] SECS_PER_DAY  = TOTAL_BITS'(86400);
   localparam logic [TOTAL_BITS-1:0] SECS_PER_HOUR = TOTAL_BITS'(3600);
   localparam logic [TOTAL_BITS-1:0] SECS_PER_MIN  = TOTAL_BITS'(60);

   localparam logic FUNC_UPDATE = 1'b0;
   localparam logic FUNC_READ   = 1'b1;

   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [TOTAL_BITS-1:0] total_type;

   typedef struct packed {
      logic        func;
      logic [31:0] entry_key;
      logic [15:0] days;
      logic [4:0]  hours;
      logic [5:0]  minutes;
      logic [5:0]  seconds;
      logic [2:0]  slot;
   } req_type;

   typedef struct packed {
      logic [2:0]  rank;
      logic        evicted;
      logic [31:0] evicted_key;
      logic [31:0] read_key;
      logic [32:0] read_total;
   } rsp_type;

   typedef struct packed {
      logic      valid;
      logic      func;
      key_type   key;
      total_type total;
      logic [2:0] slot;
   } op_type;

endpackage

### design/rft_table.sv
// ranking table storage, single-pass update and read, result register
module rft_table
   import rft_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  op_type  op,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   key_type   keys_ff   [NUM_SLOTS];
   key_type   keys_in   [NUM_SLOTS];
   total_type totals_ff [NUM_SLOTS];
   total_type totals_in [NUM_SLOTS];
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      rsp_valid_ff;

   always_comb begin
      logic                found;
      logic                ins_found;
      logic                up_ok;
      logic [POS_BITS-1:0] pos;
      logic [POS_BITS-1:0] ins;
      logic [NUM_SLOTS-1:0] ge;
      keys_in   = keys_ff;
      totals_in = totals_ff;
      rsp_in    = '0;
      found     = 1'b0;
      ins_found = 1'b0;
      up_ok     = 1'b0;
      pos       = POS_BITS'(NUM_SLOTS);
      ins       = POS_BITS'(NUM_SLOTS);
      for (int i = 0; i < NUM_SLOTS; i++) begin
         ge[i] = (op.total >= totals_ff[i]);
         if (!found && keys_ff[i] == op.key) begin
            found = 1'b1;
            pos   = POS_BITS'(i);
         end
         if (!ins_found && ge[i]) begin
            ins_found = 1'b1;
            ins       = POS_BITS'(i);
         end
      end
      if (op.func == FUNC_READ) begin
         for (int j = 0; j < NUM_SLOTS; j++) begin
            if (32'(op.slot) == j) begin
               rsp_in.read_key   = 32'(keys_ff[j]);
               rsp_in.read_total = 33'(totals_ff[j]);
            end
         end
      end else if (!found) begin
         if (ins_found) begin
            rsp_in.evicted     = 1'b1;
            rsp_in.evicted_key = 32'(keys_ff[NUM_SLOTS-1]);
            rsp_in.rank        = 3'(ins);
            for (int j = 1; j < NUM_SLOTS; j++) begin
               if (j > 32'(ins)) begin
                  keys_in[j]   = keys_ff[j-1];
                  totals_in[j] = totals_ff[j-1];
               end
            end
            for (int j = 0; j < NUM_SLOTS; j++) begin
               if (32'(ins) == j) begin
                  keys_in[j]   = op.key;
                  totals_in[j] = op.total;
               end
            end
         end else begin
            rsp_in.rank = 3'(NUM_SLOTS);
         end
      end else if (pos == '0) begin
         totals_in[0] = op.total;
         rsp_in.rank  = '0;
      end else begin
         for (int j = 1; j < NUM_SLOTS; j++) begin
            if (32'(pos) == j) begin
               up_ok = ge[j-1];
            end
         end
         if (up_ok) begin
            for (int j = 1; j < NUM_SLOTS; j++) begin
               if (32'(pos) == j) begin
                  keys_in[j]     = keys_ff[j-1];
                  totals_in[j]   = totals_ff[j-1];
                  keys_in[j-1]   = op.key;
                  totals_in[j-1] = op.total;
               end
            end
            rsp_in.rank = 3'(pos - POS_BITS'(1));
         end else begin
            for (int j = 0; j < NUM_SLOTS; j++) begin
               if (32'(pos) == j) begin
                  totals_in[j] = op.total;
               end
            end
            rsp_in.rank = 3'(pos);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff      <= '{default: '0};
         totals_ff    <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= op.valid;
         if (op.valid) begin
            keys_ff   <= keys_in;
            totals_ff <= totals_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op.valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_evict_rank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.evicted) |-> (32'(rsp_ff.rank) < NUM_SLOTS))
      else $error("eviction reported without a listed rank");

   a_evict_key_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.evicted) |-> (rsp_ff.evicted_key == '0))
      else $error("evicted key set without an eviction");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      op.valid |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_insert_lands: assert property (@(posedge clock) disable iff (reset)
      (op.valid && op.func == FUNC_UPDATE && !reset)
      |=> (keys_ff[0] == $past(op.key) || keys_ff[1] == $past(op.key) ||
           rsp_ff.rank != '0 || rsp_ff.evicted))
      else $error("update to slot zero lost its key");

endmodule

### design/top_five_ranking_table_core.sv
// top level of the five-slot ranking table: time conversion, input register, table
// a result strobes on rsp_valid after the input register and the result register
// throughput: one item per cycle, busy is never raised; the table updates in one pass
// the receiver cannot stall: each result is on the rsp ports for one cycle only
// reset (synchronous, active high) clears every slot to key 0 and total 0
module top_five_ranking_table_core
   import rft_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   op_type    op_ff;
   op_type    op_in;
   total_type total;

   assign busy = 1'b0;

   assign total = TOTAL_BITS'(TOTAL_BITS'(req_item.days) * SECS_PER_DAY)
                + TOTAL_BITS'(TOTAL_BITS'(req_item.hours) * SECS_PER_HOUR)
                + TOTAL_BITS'(TOTAL_BITS'(req_item.minutes) * SECS_PER_MIN)
                + TOTAL_BITS'(req_item.seconds);

   always_comb begin
      op_in.valid = start && !busy;
      op_in.func  = req_item.func;
      op_in.key   = KEY_BITS'(req_item.entry_key);
      op_in.total = total;
      op_in.slot  = req_item.slot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff.valid <= 1'b0;
      end else begin
         op_ff.valid <= op_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      op_ff.func  <= op_in.func;
      op_ff.key   <= op_in.key;
      op_ff.total <= op_in.total;
      op_ff.slot  <= op_in.slot;
   end

   rft_table u_table (
      .clock     (clock),
      .reset     (reset),
      .op        (op_ff),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

### test/tb.sv
// self-checking testbench for the five-slot ranking table core
module tb
   import rft_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 1000;
   localparam int PHASES      = 7;
   localparam int PHASE_ITEMS = 250;

   typedef struct {
      req_type item;
      int      gap;
      bit      drain;
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   pending_type pending_items[$];
   rsp_type     due_results[$];
   key_type     shadow_keys[NUM_SLOTS];
   total_type   shadow_totals[NUM_SLOTS];
   key_type     key_pool[8];
   int          gap_left = 0;
   int          quiet_cycles = 0;
   int          mismatches = 0;

   top_five_ranking_table_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always #6 clock = ~clock;

   function automatic total_type total_of(req_type r);
      return SECS_PER_DAY * total_type'(r.days) + SECS_PER_HOUR * total_type'(r.hours) +
             SECS_PER_MIN * total_type'(r.minutes) + total_type'(r.seconds);
   endfunction

   function automatic rsp_type rank_entry(req_type r);
      rsp_type   o;
      key_type   k;
      total_type t;
      int        pos;
      int        i;
      int        j;
      bit        placed;
      o = '0;
      if (r.func == FUNC_READ) begin
         if (r.slot < NUM_SLOTS) begin
            o.read_key   = shadow_keys[r.slot];
            o.read_total = shadow_totals[r.slot];
         end
      end else begin
         k = r.entry_key;
         t = total_of(r);
         pos = NUM_SLOTS;
         for (i = NUM_SLOTS - 1; i >= 0; i--)
            if (shadow_keys[i] == k) pos = i;
         if (pos == NUM_SLOTS) begin
            o.rank = 3'(NUM_SLOTS);
            placed = 1'b0;
            for (i = 0; i < NUM_SLOTS; i++) begin
               if (!placed && t >= shadow_totals[i]) begin
                  placed = 1'b1;
                  o.evicted     = 1'b1;
                  o.evicted_key = shadow_keys[NUM_SLOTS - 1];
                  for (j = NUM_SLOTS - 1; j > i; j--) begin
                     shadow_keys[j]   = shadow_keys[j - 1];
                     shadow_totals[j] = shadow_totals[j - 1];
                  end
                  shadow_keys[i]   = k;
                  shadow_totals[i] = t;
                  o.rank = 3'(i);
               end
            end
         end else if (pos == 0) begin
            shadow_totals[0] = t;
            o.rank = '0;
         end else if (t >= shadow_totals[pos - 1]) begin
            shadow_keys[pos]       = shadow_keys[pos - 1];
            shadow_totals[pos]     = shadow_totals[pos - 1];
            shadow_keys[pos - 1]   = k;
            shadow_totals[pos - 1] = t;
            o.rank = 3'(pos - 1);
         end else begin
            shadow_totals[pos] = t;
            o.rank = 3'(pos);
         end
      end
      return o;
   endfunction

   function automatic void queue_item(req_type r, int gap);
      pending_type p;
      p.item  = r;
      p.gap   = gap;
      p.drain = 1'b0;
      pending_items = {pending_items, p};
   endfunction

   function automatic void queue_drain();
      pending_type p;
      p.item  = '0;
      p.gap   = 0;
      p.drain = 1'b1;
      pending_items = {pending_items, p};
   endfunction

   function automatic void queue_update(key_type k, int d, int h, int m, int s);
      req_type r;
      r = '0;
      r.func      = FUNC_UPDATE;
      r.entry_key = k;
      r.days      = 16'(d);
      r.hours     = 5'(h);
      r.minutes   = 6'(m);
      r.seconds   = 6'(s);
      queue_item(r, 0);
   endfunction

   function automatic void queue_read(int slot);
      req_type r;
      r = '0;
      r.func = FUNC_READ;
      r.slot = 3'(slot);
      queue_item(r, 0);
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.func      = ($urandom_range(0, 3) == 0) ? FUNC_READ : FUNC_UPDATE;
      r.entry_key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 7)] : $urandom;
      r.days      = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      r.hours     = ($urandom_range(0, 15) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
      r.minutes   = ($urandom_range(0, 15) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
      r.seconds   = ($urandom_range(0, 15) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
      r.slot      = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(0, 4));
      // coarse totals so that ties and swaps come up often
      if ($urandom_range(0, 7) == 0) begin
         r.days    = 16'($urandom_range(0, 3));
         r.hours   = '0;
         r.minutes = '0;
         r.seconds = '0;
      end
      return r;
   endfunction

   function automatic int pick_gap(bit idle_on);
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_on || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t ns: %s: got %0h, want %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // driver: one transfer per rising edge with start high and busy low
   always @(posedge clock) begin
      pending_type next_up;
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy) due_results = {due_results, rank_entry(req_item)};
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               start <= 1'b0;
               gap_left--;
            end else if (pending_items.size() == 0) begin
               start <= 1'b0;
            end else if (pending_items[0].drain) begin
               start <= 1'b0;
               if (due_results.size() == 0) void'(pending_items.pop_front());
            end else begin
               next_up = pending_items.pop_front();
               req_item <= next_up.item;
               start <= 1'b1;
               gap_left = next_up.gap;
            end
         end
      end
   end

   // monitor: results are valid for one cycle only
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (due_results.size() == 0) begin
            report_mismatch("result with nothing due", 64'(1), 64'(0));
         end else begin
            want = due_results.pop_front();
            check_field("rank", 64'(rsp_item.rank), 64'(want.rank));
            check_field("evicted", 64'(rsp_item.evicted), 64'(want.evicted));
            check_field("evicted_key", 64'(rsp_item.evicted_key), 64'(want.evicted_key));
            check_field("read_key", 64'(rsp_item.read_key), 64'(want.read_key));
            check_field("read_total", 64'(rsp_item.read_total), 64'(want.read_total));
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int p;
      int n;
      for (n = 0; n < NUM_SLOTS; n++) begin
         shadow_keys[n]   = '0;
         shadow_totals[n] = '0;
      end

      // reads of the cleared table, including an out of range slot
      queue_read(0);
      queue_read(4);
      queue_read(7);
      // key 0 matches an empty slot
      queue_update(32'h0, 0, 0, 0, 0);
      // largest total with time fields beyond their range
      queue_update(32'hFFFF_FFFF, 65535, 31, 63, 63);
      queue_update(32'h0, 0, 0, 1, 40);
      queue_update(32'h0, 65535, 31, 63, 63);
      queue_update(32'h1, 1, 0, 0, 0);
      queue_update(32'h2, 2, 0, 0, 0);
      queue_update(32'h3, 3, 0, 0, 0);
      // too small to be listed
      queue_update(32'h4, 0, 0, 0, 1);
      queue_update(32'h1, 5, 0, 0, 0);
      queue_update(32'h2, 0, 1, 0, 0);
      // tie with a listed total
      queue_update(32'h5, 3, 0, 0, 0);
      for (n = 0; n < NUM_SLOTS; n++) queue_read(n);
      queue_read(5);
      queue_update(32'h6, 0, 23, 59, 59);
      queue_drain();

      for (p = 0; p < PHASES; p++) begin
         key_pool[0] = '0;
         key_pool[1] = '1;
         for (n = 2; n < 8; n++) key_pool[n] = $urandom;
         for (n = 0; n < PHASE_ITEMS; n++) queue_item(random_request(), pick_gap(p % 2 == 1));
         queue_drain();
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_items.size() != 0 || start || due_results.size() != 0);
      repeat (8) @(posedge clock);

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### sim.f
design/rft_pkg.sv
design/rft_table.sv
design/top_five_ranking_table_core.sv
test/tb.sv
